// File: rtl/core/eight_bit_alu_with_flags_assert.svh
// Assertion macros for the eight-bit ALU with flags.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef EIGHT_BIT_ALU_WITH_FLAGS_ASSERT_SVH
`define EIGHT_BIT_ALU_WITH_FLAGS_ASSERT_SVH

`ifndef SYNTHESIS

// Check that is switched off while reset is high
`define ALU8F_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that also holds across reset
`define ALU8F_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ALU8F_ASSERT(lbl, clk, rst, prop, msg)
`define ALU8F_ASSERT_NR(lbl, clk, prop, msg)

`endif

`endif

// File: rtl/core/alu8f_pkg.sv
// Shared types, operation codes and flag helpers for the eight-bit ALU.
// No dependencies; imported by every module of the block.
package alu8f_pkg;

  // Operation codes carried in the kind field
  localparam logic [4:0] KIND_ADD = 5'd0;
  localparam logic [4:0] KIND_ADC = 5'd1;
  localparam logic [4:0] KIND_SUB = 5'd2;
  localparam logic [4:0] KIND_SBB = 5'd3;
  localparam logic [4:0] KIND_AND = 5'd4;
  localparam logic [4:0] KIND_XOR = 5'd5;
  localparam logic [4:0] KIND_OR  = 5'd6;
  localparam logic [4:0] KIND_CMP = 5'd7;
  localparam logic [4:0] KIND_INC = 5'd8;
  localparam logic [4:0] KIND_DEC = 5'd9;
  localparam logic [4:0] KIND_RLC = 5'd10;
  localparam logic [4:0] KIND_RRC = 5'd11;
  localparam logic [4:0] KIND_RAL = 5'd12;
  localparam logic [4:0] KIND_RAR = 5'd13;
  localparam logic [4:0] KIND_DAA = 5'd14;
  localparam logic [4:0] KIND_CMA = 5'd15;
  localparam logic [4:0] KIND_STC = 5'd16;
  localparam logic [4:0] KIND_CMC = 5'd17;

  // Flag byte layout
  localparam logic [7:0] FLAG_S    = 8'h80;
  localparam logic [7:0] FLAG_Z    = 8'h40;
  localparam logic [7:0] FLAG_AC   = 8'h10;
  localparam logic [7:0] FLAG_P    = 8'h04;
  localparam logic [7:0] FLAG_ONE  = 8'h02;
  localparam logic [7:0] FLAG_C    = 8'h01;
  localparam logic [7:0] FLAG_KEEP = 8'hD5;
  localparam int         FLAG_C_BIT  = 0;
  localparam int         FLAG_AC_BIT = 4;

  // Decimal adjust constants
  localparam logic [7:0] DAA_LO_CORR = 8'h06;
  localparam logic [7:0] DAA_HI_CORR = 8'h60;
  localparam logic [7:0] DAA_HI_MAX  = 8'h99;
  localparam logic [3:0] DAA_LO_MAX  = 4'h9;

  // Widths of the stream payloads
  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 5;
  localparam int OUT_DATA_W = 16;

  // One operation as held in the input register
  typedef struct packed {
    logic [4:0] kind;
    logic [7:0] acc;
    logic [7:0] operand;
    logic [7:0] flags;
  } alu8f_item_t;

  // One finished result
  typedef struct packed {
    logic [7:0] result;
    logic [7:0] flags;
  } alu8f_res_t;

  // Sign, zero and even parity of a value, placed in the flag byte
  function automatic logic [7:0] szp(input logic [7:0] v);
    logic [7:0] f;
    f = 8'h00;
    if (v[7]) f = f | FLAG_S;
    if (v == 8'h00) f = f | FLAG_Z;
    if (!(^v)) f = f | FLAG_P;
    return f;
  endfunction

endpackage

// File: rtl/core/alu8f_in_stage.sv
// Input register of the eight-bit ALU: takes one operation per transfer.
// Depends on alu8f_pkg.
module alu8f_in_stage
  import alu8f_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_DATA_W-1:0] s_tdata,   // [7:0] acc, [15:8] operand, [23:16] flags_in
  input  logic [IN_USER_W-1:0] s_tuser,   // [4:0] kind
  input  logic                 adv,       // downstream takes the held item this cycle
  output logic                 item_valid,
  output alu8f_item_t          item
);

  logic s_take;

  // Free when empty or when the held item moves on
  assign s_tready = !item_valid || adv;
  assign s_take   = s_tvalid && s_tready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_take) begin
      item_valid <= 1'b1;
    end else if (adv) begin
      item_valid <= 1'b0;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (s_take) begin
      item.kind    <= s_tuser;
      item.acc     <= s_tdata[7:0];
      item.operand <= s_tdata[15:8];
      item.flags   <= s_tdata[23:16];
    end
  end

endmodule

// File: rtl/core/alu8f_exec.sv
// Combinational datapath of the eight-bit ALU: result value and new flag byte.
// Depends on alu8f_pkg.
module alu8f_exec
  import alu8f_pkg::*;
(
  input  alu8f_item_t item,
  output alu8f_res_t  res
);

  logic       c;
  logic       sub_op;
  logic       cin;
  logic [7:0] bb;
  logic [8:0] sum;
  logic [4:0] half;
  logic [7:0] add_f;
  logic [7:0] inc_v;
  logic [7:0] dec_v;
  logic [7:0] daa_corr;
  logic [7:0] daa_v;
  logic [4:0] daa_half;
  logic       daa_c;
  logic [7:0] rot_f;
  logic [7:0] r;
  logic [7:0] f;

  assign c = item.flags[FLAG_C_BIT];

  // Shared adder for the add and subtract family
  always_comb begin
    sub_op = (item.kind == KIND_SUB) || (item.kind == KIND_SBB) || (item.kind == KIND_CMP);
    case (item.kind)
      KIND_ADC: cin = c;
      KIND_SUB: cin = 1'b1;
      KIND_SBB: cin = ~c;
      KIND_CMP: cin = 1'b1;
      default:  cin = 1'b0;
    endcase
  end

  assign bb    = sub_op ? ~item.operand : item.operand;
  assign sum   = {1'b0, item.acc} + {1'b0, bb} + {8'h00, cin};
  assign half  = {1'b0, item.acc[3:0]} + {1'b0, bb[3:0]} + {4'h0, cin};
  assign add_f = szp(sum[7:0]) | (half[4] ? FLAG_AC : 8'h00)
               | ((sum[8] ^ sub_op) ? FLAG_C : 8'h00);

  // Increment and decrement of the operand
  assign inc_v = item.operand + 8'h01;
  assign dec_v = item.operand - 8'h01;

  // Decimal adjust
  always_comb begin
    daa_corr = 8'h00;
    daa_c    = c;
    if ((item.acc[3:0] > DAA_LO_MAX) || item.flags[FLAG_AC_BIT]) begin
      daa_corr = daa_corr | DAA_LO_CORR;
    end
    if ((item.acc > DAA_HI_MAX) || c) begin
      daa_corr = daa_corr | DAA_HI_CORR;
      daa_c    = 1'b1;
    end
  end

  assign daa_v    = item.acc + daa_corr;
  assign daa_half = {1'b0, item.acc[3:0]} + {1'b0, daa_corr[3:0]};

  // Rotates keep every flag but carry
  assign rot_f = item.flags & FLAG_KEEP & ~FLAG_C;

  // Operation select
  always_comb begin
    r = item.acc;
    f = item.flags & FLAG_KEEP;
    case (item.kind)
      KIND_ADD, KIND_ADC, KIND_SUB, KIND_SBB: begin
        r = sum[7:0];
        f = add_f;
      end
      KIND_CMP: begin
        f = add_f;
      end
      KIND_AND: begin
        r = item.acc & item.operand;
        f = szp(item.acc & item.operand)
          | (((item.acc | item.operand) & 8'h08) != 8'h00 ? FLAG_AC : 8'h00);
      end
      KIND_XOR: begin
        r = item.acc ^ item.operand;
        f = szp(item.acc ^ item.operand);
      end
      KIND_OR: begin
        r = item.acc | item.operand;
        f = szp(item.acc | item.operand);
      end
      KIND_INC: begin
        r = inc_v;
        f = szp(inc_v) | (c ? FLAG_C : 8'h00) | ((inc_v[3:0] == 4'h0) ? FLAG_AC : 8'h00);
      end
      KIND_DEC: begin
        r = dec_v;
        f = szp(dec_v) | (c ? FLAG_C : 8'h00) | ((dec_v[3:0] != 4'hF) ? FLAG_AC : 8'h00);
      end
      KIND_RLC: begin
        r = {item.acc[6:0], item.acc[7]};
        f = rot_f | {7'h00, item.acc[7]};
      end
      KIND_RRC: begin
        r = {item.acc[0], item.acc[7:1]};
        f = rot_f | {7'h00, item.acc[0]};
      end
      KIND_RAL: begin
        r = {item.acc[6:0], c};
        f = rot_f | {7'h00, item.acc[7]};
      end
      KIND_RAR: begin
        r = {c, item.acc[7:1]};
        f = rot_f | {7'h00, item.acc[0]};
      end
      KIND_DAA: begin
        r = daa_v;
        f = szp(daa_v) | (daa_c ? FLAG_C : 8'h00) | (daa_half[4] ? FLAG_AC : 8'h00);
      end
      KIND_CMA: begin
        r = ~item.acc;
      end
      KIND_STC: begin
        f = (item.flags & FLAG_KEEP) | FLAG_C;
      end
      KIND_CMC: begin
        f = (item.flags & FLAG_KEEP) ^ FLAG_C;
      end
      default: begin
        r = item.acc;
        f = item.flags & FLAG_KEEP;
      end
    endcase
  end

  // Normalise the flag byte
  assign res.result = r;
  assign res.flags  = (f & FLAG_KEEP) | FLAG_ONE;

endmodule

// File: rtl/core/alu8f_out_stage.sv
// Result register of the eight-bit ALU, driving the master-side stream.
// Depends on alu8f_pkg.
module alu8f_out_stage
  import alu8f_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  res_valid,
  input  alu8f_res_t            res,
  output logic                  adv,       // result register can load this cycle
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // [7:0] result, [15:8] flags_out
);

  alu8f_res_t hold;

  // Loads when empty or when the current result is being transferred
  assign adv = !m_tvalid || m_tready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= res_valid;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      hold <= res;
    end
  end

  assign m_tdata = {hold.flags, hold.result};

endmodule

// File: rtl/core/eight_bit_alu_with_flags.sv
// Eight-bit accumulator ALU with flags, two-register stream pipeline: an operation
// enters on the slave stream (kind in tuser; acc, operand and flag byte in tdata),
// is evaluated in one pass of combinational logic between the input register and
// the result register, and leaves as result plus normalised flag byte on the master
// stream. One operation is accepted per cycle while m_tready does not stall the
// pipeline; m_tvalid rises once the operation has moved from the input register
// into the result register. Back-pressure from m_tready reaches s_tready through
// the two stages; up to two operations are held. Depends on alu8f_pkg, alu8f_in_stage,
// alu8f_exec, alu8f_out_stage and eight_bit_alu_with_flags_assert.svh.
`include "eight_bit_alu_with_flags_assert.svh"

module eight_bit_alu_with_flags
  import alu8f_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] acc, [15:8] operand, [23:16] flags_in
  input  logic [IN_USER_W-1:0]  s_tuser,   // [4:0] kind
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // [7:0] result, [15:8] flags_out
);

  logic        item_valid;
  logic        adv;
  alu8f_item_t item;
  alu8f_res_t  res;

  // Input register
  alu8f_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .adv        (adv),
    .item_valid (item_valid),
    .item       (item)
  );

  // Datapath
  alu8f_exec u_exec (
    .item (item),
    .res  (res)
  );

  // Result register
  alu8f_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (item_valid),
    .res       (res),
    .adv       (adv),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // Checks
  `ALU8F_ASSERT_NR(a_reset_empty, clk, rst |=> (!item_valid && !m_tvalid), "pipeline not empty after reset")
  `ALU8F_ASSERT(a_stall_holds, clk, rst, (item_valid && m_tvalid && !m_tready) |=> (item_valid && $stable(item)), "held operation lost while output stalled")
  `ALU8F_ASSERT(a_empty_ready, clk, rst, !item_valid |-> s_tready, "input refused while input register empty")
  `ALU8F_ASSERT(a_flag_fixed, clk, rst, m_tvalid |-> (m_tdata[9] && !m_tdata[11] && !m_tdata[13]), "fixed flag bits wrong")

endmodule

// File: dv/tb_eight_bit_alu_with_flags.sv
`timescale 1ns / 1ps
// Testbench for eight_bit_alu_with_flags: directed table then random operations
// over the stream ports, each result checked against its typed table entry or
// a local flag-exact model. Depends on alu8f_pkg and the RTL of the block only.
module tb_eight_bit_alu_with_flags;
  import alu8f_pkg::*;

  // Codes outside the defined operation set; the block passes acc through
  localparam logic [4:0] KIND_SPARE_LO = 5'd18;
  localparam logic [4:0] KIND_SPARE_HI = 5'd31;

  localparam int N_DIR       = 27;
  localparam int N_RAND      = 1400;
  localparam int N_TAIL      = 150;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [4:0] kind;
    logic [7:0] acc;
    logic [7:0] opnd;
    logic [7:0] flg;
    logic       typed;
    logic [7:0] res;
    logic [7:0] fl;
  } op_row_t;

  typedef struct {
    int         seq;
    logic [4:0] kind;
    alu8f_res_t want;
  } alu_due_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // [7:0] acc, [15:8] operand, [23:16] flags_in
  logic [IN_USER_W-1:0]  s_tuser;   // [4:0] kind
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // [7:0] result, [15:8] flags_out

  alu_due_t alu_due[$];
  op_row_t  dir_tab [N_DIR];
  int       errors = 0;
  int       cycle_count = 0;
  bit       in_tail = 1'b0;

  eight_bit_alu_with_flags DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Clock and a single reset at the start
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
  end

  // Sign, zero and even parity placed in the flag byte
  function automatic logic [7:0] sign_zero_parity(input logic [7:0] v);
    return (v[7] ? FLAG_S : 8'h00) | ((v == 8'h00) ? FLAG_Z : 8'h00) |
           ((~^v) ? FLAG_P : 8'h00);
  endfunction

  // Expected value and flag byte of one operation
  function automatic alu8f_res_t alu_eval(input logic [4:0] k, input logic [7:0] a,
                                          input logic [7:0] b, input logic [7:0] fi);
    logic [8:0] sum;
    logic [7:0] bb, r, f, corr;
    logic       cin, cy, is_sub, nc;
    alu8f_res_t out;
    r  = a;
    f  = fi & FLAG_KEEP;
    cy = fi[FLAG_C_BIT];
    case (k)
      KIND_ADD, KIND_ADC, KIND_SUB, KIND_SBB, KIND_CMP: begin
        // subtract family adds the inverted operand and inverted borrow
        is_sub = (k == KIND_SUB) || (k == KIND_SBB) || (k == KIND_CMP);
        bb = is_sub ? ~b : b;
        case (k)
          KIND_ADD: cin = 1'b0;
          KIND_ADC: cin = cy;
          KIND_SBB: cin = ~cy;
          default:  cin = 1'b1;
        endcase
        sum = {1'b0, a} + {1'b0, bb} + {8'h00, cin};
        f = sign_zero_parity(sum[7:0]);
        if (({1'b0, a[3:0]} + {1'b0, bb[3:0]} + {4'h0, cin}) > 5'h0F) f = f | FLAG_AC;
        if (sum[8] != is_sub) f = f | FLAG_C;
        if (k != KIND_CMP) r = sum[7:0];
      end
      KIND_AND: begin
        r  = a & b;
        bb = a | b;
        f  = sign_zero_parity(r) | (bb[3] ? FLAG_AC : 8'h00);
      end
      KIND_XOR: begin
        r = a ^ b;
        f = sign_zero_parity(r);
      end
      KIND_OR: begin
        r = a | b;
        f = sign_zero_parity(r);
      end
      KIND_INC: begin
        r = b + 8'd1;
        f = sign_zero_parity(r) | {7'b0, cy} | ((r[3:0] == 4'h0) ? FLAG_AC : 8'h00);
      end
      KIND_DEC: begin
        r = b - 8'd1;
        f = sign_zero_parity(r) | {7'b0, cy} | ((r[3:0] != 4'hF) ? FLAG_AC : 8'h00);
      end
      KIND_RLC: begin
        r = {a[6:0], a[7]};
        f = (fi & FLAG_KEEP & ~FLAG_C) | {7'b0, a[7]};
      end
      KIND_RRC: begin
        r = {a[0], a[7:1]};
        f = (fi & FLAG_KEEP & ~FLAG_C) | {7'b0, a[0]};
      end
      KIND_RAL: begin
        r = {a[6:0], cy};
        f = (fi & FLAG_KEEP & ~FLAG_C) | {7'b0, a[7]};
      end
      KIND_RAR: begin
        r = {cy, a[7:1]};
        f = (fi & FLAG_KEEP & ~FLAG_C) | {7'b0, a[0]};
      end
      KIND_DAA: begin
        // low and high digit corrections; carry only ever set here
        corr = 8'h00;
        nc   = cy;
        if (a[3:0] > DAA_LO_MAX || fi[FLAG_AC_BIT]) corr = corr | DAA_LO_CORR;
        if (a > DAA_HI_MAX || cy) begin
          corr = corr | DAA_HI_CORR;
          nc   = 1'b1;
        end
        r = a + corr;
        f = sign_zero_parity(r) | {7'b0, nc};
        if (({1'b0, a[3:0]} + {1'b0, corr[3:0]}) > 5'h0F) f = f | FLAG_AC;
      end
      KIND_CMA: r = ~a;
      KIND_STC: f = f | FLAG_C;
      KIND_CMC: f = f ^ FLAG_C;
      default: ;
    endcase
    out.result = r;
    out.flags  = (f & FLAG_KEEP) | FLAG_ONE;
    return out;
  endfunction

  task automatic report_mismatch(input string what, input int seq, input logic [4:0] k,
                                 input logic [7:0] got, input logic [7:0] want);
    $display("%0t: op %0d kind %0d: %s got %02h, expected %02h",
             $time, seq, k, what, got, want);
    errors++;
  endtask

  // Present one operation and hold it until the transfer; book its result
  task automatic send_op(input int seq, input op_row_t row);
    alu_due_t due;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {row.flg, row.opnd, row.acc};
    s_tuser  <= row.kind;
    do @(posedge clk); while (!s_tready);
    due.seq  = seq;
    due.kind = row.kind;
    if (row.typed) begin
      due.want.result = row.res;
      due.want.flags  = row.fl;
    end else begin
      due.want = alu_eval(row.kind, row.acc, row.opnd, row.flg);
    end
    alu_due.push_back(due);
  endtask

  task automatic idle_for(input int n);
    @(negedge clk);
    s_tvalid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Operand bytes lean towards the boundary values now and then
  function automatic logic [7:0] pick_byte();
    logic [7:0] edges [8];
    edges = '{8'h00, 8'hFF, 8'h7F, 8'h80, 8'h0F, 8'hF0, 8'h99, 8'h9A};
    if ($urandom_range(0, 3) == 0) return edges[$urandom_range(0, 7)];
    return 8'($urandom_range(0, 255));
  endfunction

  // Stimulus: directed table, then random operations
  initial begin : stimulus
    op_row_t row;
    int      seq;
    int      idle_rate;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    seq       = 0;
    idle_rate = 2;

    // kind, acc, operand, flags_in, typed, result, flags_out
    dir_tab[0]  = '{KIND_ADD, 8'hFF, 8'h01, 8'h00, 1'b1, 8'h00, 8'h57};
    dir_tab[1]  = '{KIND_ADD, 8'h00, 8'h00, 8'hFF, 1'b1, 8'h00, 8'h46};
    dir_tab[2]  = '{KIND_ADC, 8'h7F, 8'h00, 8'h01, 1'b0, 8'h00, 8'h00};
    dir_tab[3]  = '{KIND_ADC, 8'hFF, 8'hFF, 8'h01, 1'b0, 8'h00, 8'h00};
    dir_tab[4]  = '{KIND_SUB, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 8'h56};
    dir_tab[5]  = '{KIND_SUB, 8'h00, 8'h01, 8'h00, 1'b0, 8'h00, 8'h00};
    dir_tab[6]  = '{KIND_SBB, 8'h10, 8'h0F, 8'h01, 1'b0, 8'h00, 8'h00};
    dir_tab[7]  = '{KIND_SBB, 8'h80, 8'h7F, 8'h00, 1'b0, 8'h00, 8'h00};
    dir_tab[8]  = '{KIND_AND, 8'hF0, 8'h0F, 8'h00, 1'b0, 8'h00, 8'h00};
    dir_tab[9]  = '{KIND_AND, 8'hFF, 8'hFF, 8'hFF, 1'b0, 8'h00, 8'h00};
    dir_tab[10] = '{KIND_XOR, 8'hAA, 8'h55, 8'hFF, 1'b0, 8'h00, 8'h00};
    dir_tab[11] = '{KIND_OR,  8'h00, 8'h00, 8'hFF, 1'b0, 8'h00, 8'h00};
    dir_tab[12] = '{KIND_CMP, 8'h42, 8'h42, 8'h00, 1'b0, 8'h00, 8'h00};
    dir_tab[13] = '{KIND_INC, 8'h00, 8'hFF, 8'h00, 1'b1, 8'h00, 8'h56};
    dir_tab[14] = '{KIND_DEC, 8'h00, 8'h00, 8'h01, 1'b1, 8'hFF, 8'h87};
    dir_tab[15] = '{KIND_RLC, 8'h80, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00};
    dir_tab[16] = '{KIND_RRC, 8'h01, 8'h00, 8'hFF, 1'b0, 8'h00, 8'h00};
    dir_tab[17] = '{KIND_RAL, 8'h80, 8'h00, 8'h01, 1'b0, 8'h00, 8'h00};
    dir_tab[18] = '{KIND_RAR, 8'h01, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00};
    dir_tab[19] = '{KIND_DAA, 8'h9A, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00};
    dir_tab[20] = '{KIND_DAA, 8'h99, 8'h00, 8'h11, 1'b0, 8'h00, 8'h00};
    dir_tab[21] = '{KIND_DAA, 8'h0F, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00};
    dir_tab[22] = '{KIND_CMA, 8'h00, 8'h00, 8'h00, 1'b1, 8'hFF, 8'h02};
    dir_tab[23] = '{KIND_STC, 8'h5A, 8'h00, 8'h00, 1'b1, 8'h5A, 8'h03};
    dir_tab[24] = '{KIND_CMC, 8'h3C, 8'h00, 8'hFF, 1'b1, 8'h3C, 8'hD6};
    dir_tab[25] = '{KIND_SPARE_HI, 8'hA5, 8'h00, 8'hFF, 1'b1, 8'hA5, 8'hD7};
    dir_tab[26] = '{KIND_SPARE_LO, 8'h00, 8'hFF, 8'h28, 1'b1, 8'h00, 8'h02};

    do @(negedge clk); while (rst);

    // Directed part, back to back
    for (int i = 0; i < N_DIR; i++) begin
      send_op(seq, dir_tab[i]);
      seq++;
    end

    // Random part; idle rate changes every hundred operations, none at the end
    for (int i = 0; i < N_RAND; i++) begin
      if (i % 100 == 0) idle_rate = $urandom_range(0, 3);
      if (i == N_RAND - N_TAIL) in_tail = 1'b1;
      row.kind  = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI))
                                              : 5'($urandom_range(KIND_ADD, KIND_CMC));
      row.acc   = pick_byte();
      row.opnd  = pick_byte();
      row.flg   = 8'($urandom_range(0, 255));
      row.typed = 1'b0;
      row.res   = 8'h00;
      row.fl    = 8'h00;
      send_op(seq, row);
      seq++;
      if (!in_tail && idle_rate != 0 && $urandom_range(1, 8) <= idle_rate)
        idle_for($urandom_range(1, 18));
    end

    @(negedge clk);
    s_tvalid <= 1'b0;

    // Drain, then allow for the pipeline latency
    while (alu_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("tb_eight_bit_alu_with_flags: PASS");
    end else begin
      $display("tb_eight_bit_alu_with_flags: FAIL");
    end
    $finish;
  end

  // Result side back-pressure in bursts
  initial begin : sink_pacing
    int n;
    int rate;
    int cyc;
    m_tready = 1'b0;
    rate = 2;
    cyc  = 0;
    do @(negedge clk); while (rst);
    m_tready <= 1'b1;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 128 == 0) rate = $urandom_range(0, 3);
      if (!in_tail && rate != 0 && $urandom_range(1, 8) <= rate) begin
        n = $urandom_range(1, 18);
        m_tready <= 1'b0;
        repeat (n - 1) @(negedge clk);
        @(negedge clk);
        m_tready <= 1'b1;
      end
    end
  end

  // Compare each result transfer with the oldest booked operation
  always @(posedge clk) begin : check_out
    alu_due_t due;
    if (!rst && m_tvalid && m_tready) begin
      if (alu_due.size() == 0) begin
        report_mismatch("result with none pending,", -1, 5'd0, m_tdata[7:0], 8'h00);
      end else begin
        due = alu_due.pop_front();
        if (m_tdata[7:0] !== due.want.result)
          report_mismatch("result", due.seq, due.kind, m_tdata[7:0], due.want.result);
        if (m_tdata[15:8] !== due.want.flags)
          report_mismatch("flags_out", due.seq, due.kind, m_tdata[15:8], due.want.flags);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_eight_bit_alu_with_flags: FAIL");
      $finish;
    end
  end

endmodule
